@@ src/dmn_pkg.sv @@
// dmn_pkg: shared types, widths and helpers for the division magic number block
// used by division_magic_number and dmn_divider; no dependencies
`default_nettype none

package dmn_pkg;

  // fixed field widths
  localparam int DIVISOR_W = 31;
  localparam int MULT_W    = 32;
  localparam int SHIFT_W   = 6;
  localparam int LOG_W     = 5;

  // bits retired per cycle by the log scan
  localparam int SCAN_STEP = 4;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_LOG     = 8'b00000010,
    S_SETUP   = 8'b00000100,
    S_DIV_LO  = 8'b00001000,
    S_SWAP    = 8'b00010000,
    S_DIV_HI  = 8'b00100000,
    S_HI_LOAD = 8'b01000000,
    S_REDUCE  = 8'b10000000
  } dmn_state_t;

  // control from the sequencer to the divider
  typedef struct packed {
    logic clear;
    logic step;
    logic bit_in;
  } dmn_div_ctrl_t;

  // bit length of a 4-bit value
  function automatic logic [2:0] bitlen4(input logic [3:0] v);
    logic [2:0] n;
    begin
      if (v[3]) begin
        n = 3'd4;
      end else if (v[2]) begin
        n = 3'd3;
      end else if (v[1]) begin
        n = 3'd2;
      end else if (v[0]) begin
        n = 3'd1;
      end else begin
        n = 3'd0;
      end
      return n;
    end
  endfunction

endpackage

`default_nettype wire

@@ src/dmn_divider.sv @@
// dmn_divider: bit-serial restoring divider, one dividend bit per step
// depends on dmn_pkg for widths and the control struct
`default_nettype none

module dmn_divider
  import dmn_pkg::*;
#(
  parameter int QUOT_W = 33
) (
  input  wire logic                 clk,
  input  wire dmn_div_ctrl_t        ctrl,
  input  wire logic [DIVISOR_W-1:0] divisor,
  output logic      [QUOT_W-1:0]    quotient
);

  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0]    quot_r, quot_nxt;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // shared compare and subtract
  always_comb begin
    trial = {rem_r, ctrl.bit_in};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // remainder and quotient update
  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (ctrl.clear) begin
      rem_nxt  = '0;
      quot_nxt = '0;
    end else if (ctrl.step) begin
      rem_nxt  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quot_nxt = {quot_r[QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign quotient = quot_r;

endmodule

`default_nettype wire

@@ src/division_magic_number.sv @@
// Magic constants for signed division by a positive constant divisor. A transaction on
// the input takes the divisor; one result follows with the low 32 bits of the upper-bound
// multiplier, the final post shift and ceil(log2 d). One divisor is processed at a time:
// in_stall is high from acceptance until the result is placed in the output register,
// which can hold a finished result while the next divisor is accepted. The two long
// divisions run one dividend bit per cycle through a single shared 32-bit compare/subtract
// unit, preceded by a log scan of four bits per cycle and followed by one bound-halving
// step per cycle. Divisor zero yields all-zero fields.
`default_nettype none

module division_magic_number
  import dmn_pkg::*;
#(
  parameter int PRECISION_BITS = 31
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [DIVISOR_W-1:0]       in_divisor,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [MULT_W-1:0]        out_magic_multiplier,
  output logic signed [SHIFT_W-1:0]       out_post_shift,
  output logic        [LOG_W-1:0]         out_ceiling_log
);

  // quotient width: bounds stay below 2^(P+1)+2, at least a full multiplier wide
  localparam int QUOT_W = (PRECISION_BITS + 2 > MULT_W) ? PRECISION_BITS + 2 : MULT_W;
  // dividend bit index width: top bit is P + l
  localparam int TOP_W  = $clog2(PRECISION_BITS + 32);

  dmn_state_t state_r, state_nxt;

  logic [DIVISOR_W-1:0]      d_r, d_nxt;
  logic [DIVISOR_W-1:0]      scan_r, scan_nxt;
  logic [LOG_W-1:0]          l_r, l_nxt;
  logic                      zero_r, zero_nxt;
  logic [TOP_W-1:0]          top_r, top_nxt;
  logic [TOP_W-1:0]          cnt_r, cnt_nxt;
  logic [QUOT_W-1:0]         lo_r, lo_nxt;
  logic [QUOT_W-1:0]         hi_r, hi_nxt;
  logic signed [SHIFT_W-1:0] sh_r, sh_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [MULT_W-1:0]  mult_out_r, mult_out_nxt;
  logic signed [SHIFT_W-1:0] shift_out_r, shift_out_nxt;
  logic [LOG_W-1:0]          log_out_r, log_out_nxt;

  dmn_div_ctrl_t             div_ctrl;
  logic [QUOT_W-1:0]         quot;
  logic                      in_take;
  logic                      out_free;
  logic                      keep_halving;

  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // shared divider
  dmn_divider #(
    .QUOT_W (QUOT_W)
  ) u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .divisor  (d_r),
    .quotient (quot)
  );

  // halving condition for the reduction loop
  assign keep_halving = ((lo_r >> 1) < (hi_r >> 1)) && (sh_r > $signed(SHIFT_W'(1)));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    scan_nxt      = scan_r;
    l_nxt         = l_r;
    zero_nxt      = zero_r;
    top_nxt       = top_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sh_nxt        = sh_r;
    out_valid_nxt = out_valid_r && out_stall;
    mult_out_nxt  = mult_out_r;
    shift_out_nxt = shift_out_r;
    log_out_nxt   = log_out_r;
    div_ctrl      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          d_nxt     = in_divisor;
          scan_nxt  = in_divisor - DIVISOR_W'(1);
          zero_nxt  = (in_divisor == '0);
          l_nxt     = '0;
          state_nxt = S_LOG;
        end
      end
      // bit length of d-1, four bits per cycle
      S_LOG: begin
        if ((scan_r >> SCAN_STEP) != '0) begin
          scan_nxt = scan_r >> SCAN_STEP;
          l_nxt    = l_r + LOG_W'(SCAN_STEP);
        end else begin
          l_nxt     = l_r + LOG_W'(bitlen4(scan_r[3:0]));
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        div_ctrl.clear = 1'b1;
        top_nxt        = TOP_W'(PRECISION_BITS) + TOP_W'(l_r);
        cnt_nxt        = TOP_W'(PRECISION_BITS) + TOP_W'(l_r);
        state_nxt      = S_DIV_LO;
      end
      // dividend 2^top
      S_DIV_LO: begin
        div_ctrl.step   = 1'b1;
        div_ctrl.bit_in = (cnt_r == top_r);
        cnt_nxt         = cnt_r - TOP_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_SWAP;
        end
      end
      S_SWAP: begin
        lo_nxt         = quot;
        div_ctrl.clear = 1'b1;
        cnt_nxt        = top_r;
        state_nxt      = S_DIV_HI;
      end
      // dividend 2^top + 2^l
      S_DIV_HI: begin
        div_ctrl.step   = 1'b1;
        div_ctrl.bit_in = (cnt_r == top_r) || (cnt_r == TOP_W'(l_r));
        cnt_nxt         = cnt_r - TOP_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_HI_LOAD;
        end
      end
      // last quotient bit has landed
      S_HI_LOAD: begin
        hi_nxt    = quot;
        sh_nxt    = $signed({1'b0, l_r});
        state_nxt = S_REDUCE;
      end
      // halve both bounds while they stay apart and the shift exceeds one, then load the result once the output is free
      S_REDUCE: begin
        if (keep_halving) begin
          lo_nxt = lo_r >> 1;
          hi_nxt = hi_r >> 1;
          sh_nxt = sh_r - SHIFT_W'(1);
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          mult_out_nxt  = zero_r ? '0 : $signed(hi_r[MULT_W-1:0]);
          shift_out_nxt = zero_r ? '0 : sh_r - SHIFT_W'(1);
          log_out_nxt   = zero_r ? '0 : l_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    scan_r      <= scan_nxt;
    l_r         <= l_nxt;
    zero_r      <= zero_nxt;
    top_r       <= top_nxt;
    cnt_r       <= cnt_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    sh_r        <= sh_nxt;
    mult_out_r  <= mult_out_nxt;
    shift_out_r <= shift_out_nxt;
    log_out_r   <= log_out_nxt;
  end

  // ports
  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_magic_multiplier = mult_out_r;
  assign out_post_shift       = shift_out_r;
  assign out_ceiling_log      = log_out_r;

`ifndef ASSERT_OFF
  // an accepted divisor always starts the log scan
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_LOG)
    else $error("accepted divisor did not start the log scan");

  // a new result only appears from the reduction step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_REDUCE)
    else $error("result loaded outside reduction");

  // the bit counter never runs past the top dividend bit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_LO || state_r == S_DIV_HI |-> cnt_r <= top_r)
    else $error("division bit counter out of range");

  // final shift stays within the range -1 to 30
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> shift_out_r >= -6'sd1 && shift_out_r <= 6'sd30)
    else $error("post shift out of range");
`endif

endmodule

`default_nettype wire
